@@ hdl/ffba_pkg.sv @@
// ffba_pkg: shared types and codes for the first-fit block allocator
// holds operation and status codes, the result kind, and the controller/datapath
// command and status structs; no dependencies
package ffba_pkg;

    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int REQ_W  = 16;
    localparam int OFF_W  = 16;
    localparam int NEED_W = 17;   // a rounded-up 16-bit request

    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
    localparam logic [OP_W-1:0] OP_RESIZE  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK   = 2'd0;
    localparam logic [ST_W-1:0] ST_NULL = 2'd1;
    localparam logic [ST_W-1:0] ST_OOM  = 2'd2;

    typedef enum logic [2:0] {
        RES_OK_ZERO,
        RES_OK_PTR,
        RES_OK_ALLOC,
        RES_OK_MOVE,
        RES_NULL,
        RES_OOM
    } t_res_kind;

    typedef struct packed {
        logic      load;
        logic      walk_start;
        logic      walk_step;
        logic      save_loc;
        logic      wr_alloc;
        logic      wr_split;
        logic      wr_free;
        logic      res_we;
        t_res_kind res_kind;
        logic      emit;
    } t_ffba_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            req_zero;
        logic            present;
        logic            walk_end;
        logic            loc_hit;
        logic            fit_hit;
        logic            fits_in_place;
        logic            can_split;
    } t_ffba_stat;

endpackage

@@ hdl/ffba_ctrl.sv @@
// ffba_ctrl: request sequencer of the first-fit block allocator
// steps through decode, chain walks and table writes; depends on ffba_pkg
module ffba_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  ffba_pkg::t_ffba_stat  i_stat,
    output logic                  o_busy,
    output ffba_pkg::t_ffba_cmd   o_cmd
);
    import ffba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_LOC_WALK,
        S_ALLOC_WALK,
        S_ALLOC_WR,
        S_SPLIT_WR,
        S_FREE_WR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   moving;

    // an allocation with a live pointer only happens for a moving resize
    assign moving = (i_stat.op == OP_RESIZE) && i_stat.present;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_kind = RES_OK_ZERO;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_stat.op == OP_ALLOC) begin
                    if (i_stat.req_zero) begin
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_kind = RES_NULL;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = S_ALLOC_WALK;
                    end
                end else if (i_stat.op == OP_RELEASE) begin
                    if (i_stat.present) begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = S_LOC_WALK;
                    end else begin
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_kind = RES_OK_ZERO;
                        n_state        = S_DONE;
                    end
                end else if (i_stat.op == OP_RESIZE) begin
                    // a null pointer with zero size is a zero-size allocate
                    if (!i_stat.present && i_stat.req_zero) begin
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_kind = RES_NULL;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                        n_state = i_stat.present ? S_LOC_WALK : S_ALLOC_WALK;
                    end
                end else begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_kind = RES_OK_ZERO;
                    n_state        = S_DONE;
                end
            end
            S_LOC_WALK: begin
                if (i_stat.walk_end) begin
                    o_cmd.res_we = 1'b1;
                    if (i_stat.op == OP_RELEASE) begin
                        o_cmd.res_kind = RES_OK_ZERO;
                    end else if (i_stat.req_zero) begin
                        o_cmd.res_kind = RES_NULL;
                    end else begin
                        o_cmd.res_kind = RES_OOM;
                    end
                    n_state = S_DONE;
                end else if (i_stat.loc_hit) begin
                    o_cmd.save_loc = 1'b1;
                    if (i_stat.op == OP_RELEASE) begin
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_kind = RES_OK_ZERO;
                        n_state        = S_FREE_WR;
                    end else if (i_stat.req_zero) begin
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_kind = RES_NULL;
                        n_state        = S_FREE_WR;
                    end else if (i_stat.fits_in_place) begin
                        o_cmd.res_we   = 1'b1;
                        o_cmd.res_kind = RES_OK_PTR;
                        n_state        = S_DONE;
                    end else begin
                        o_cmd.walk_start = 1'b1;
                        n_state          = S_ALLOC_WALK;
                    end
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_ALLOC_WALK: begin
                if (i_stat.walk_end) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_kind = RES_OOM;
                    n_state        = S_DONE;
                end else if (i_stat.fit_hit) begin
                    o_cmd.res_we   = 1'b1;
                    o_cmd.res_kind = moving ? RES_OK_MOVE : RES_OK_ALLOC;
                    n_state        = S_ALLOC_WR;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_ALLOC_WR: begin
                o_cmd.wr_alloc = 1'b1;
                if (i_stat.can_split) begin
                    n_state = S_SPLIT_WR;
                end else begin
                    n_state = moving ? S_FREE_WR : S_DONE;
                end
            end
            S_SPLIT_WR: begin
                o_cmd.wr_split = 1'b1;
                n_state        = moving ? S_FREE_WR : S_DONE;
            end
            S_FREE_WR: begin
                o_cmd.wr_free = 1'b1;
                n_state       = S_DONE;
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_busy = r_busy;

endmodule

@@ hdl/ffba_dpath.sv @@
// ffba_dpath: block table, chain walker and result registers of the allocator
// blocks form a linked list in creation-order slots; depends on ffba_pkg
module ffba_dpath #(
    parameter int HEAP_BYTES      = 65536,
    parameter int HEADER_BYTES    = 24,
    parameter int MIN_SPLIT_BYTES = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ffba_pkg::t_ffba_cmd                i_cmd,
    input  logic [ffba_pkg::OP_W-1:0]          i_operation,
    input  logic [ffba_pkg::REQ_W-1:0]         i_request_bytes,
    input  logic                               i_pointer_present,
    input  logic [ffba_pkg::OFF_W-1:0]         i_pointer_offset,
    output ffba_pkg::t_ffba_stat               o_stat,
    output logic [ffba_pkg::ST_W-1:0]          o_status,
    output logic [ffba_pkg::OFF_W-1:0]         o_result_offset,
    output logic [ffba_pkg::OFF_W-1:0]         o_copy_bytes,
    output logic                               o_done
);
    import ffba_pkg::*;

    localparam int SLOTS = HEAP_BYTES / (HEADER_BYTES + 8) + 1;
    localparam int IW    = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int SW    = $clog2(HEAP_BYTES + 1);
    localparam int XW    = ((SW > NEED_W) ? SW : NEED_W) + 1;
    localparam int EW    = SW + 1 + IW;

    // table entry: payload size, free flag, next slot in address order
    logic [EW-1:0] mem [SLOTS];

    logic [OP_W-1:0]   r_op;
    logic [REQ_W-1:0]  r_req;
    logic              r_present;
    logic [OFF_W-1:0]  r_ptr;
    logic [NEED_W-1:0] r_need;

    logic [EW-1:0]     r_rd_word;
    logic              r_rd_fresh;
    logic              r_head_fresh;
    logic [CW-1:0]     r_count;

    logic [IW-1:0]     r_cur;
    logic [SW-1:0]     r_addr;
    logic [CW-1:0]     r_cnt;

    logic [IW-1:0]     r_loc_slot;
    logic [SW-1:0]     r_loc_size;
    logic [IW-1:0]     r_loc_next;

    logic [ST_W-1:0]   r_status;
    logic [OFF_W-1:0]  r_result;
    logic [OFF_W-1:0]  r_copy;
    logic              r_done;

    logic [SW-1:0]     eff_size;
    logic              eff_free;
    logic [IW-1:0]     eff_next;
    logic [XW-1:0]     pay_off;
    logic              rd_en;
    logic [IW-1:0]     rd_addr;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [EW-1:0]     wr_word;
    logic              can_split;
    logic [SW-1:0]     rest_size;
    logic [NEED_W-1:0] need;

    // head slot reads as the whole heap until it is first written
    always_comb begin
        if (r_rd_fresh) begin
            eff_size = SW'(HEAP_BYTES - HEADER_BYTES);
            eff_free = 1'b1;
            eff_next = '0;
        end else begin
            eff_size = r_rd_word[EW-1 -: SW];
            eff_free = r_rd_word[IW];
            eff_next = r_rd_word[IW-1:0];
        end
    end

    assign pay_off   = XW'(r_addr) + XW'(HEADER_BYTES);
    assign can_split = (XW'(eff_size) >= XW'(r_need) + XW'(HEADER_BYTES) + XW'(MIN_SPLIT_BYTES))
                    && (r_count < CW'(SLOTS));
    assign rest_size = SW'(XW'(eff_size) - XW'(r_need) - XW'(HEADER_BYTES));
    assign need      = (NEED_W'(i_request_bytes) + NEED_W'(7)) & ~NEED_W'(7);

    assign rd_en   = i_cmd.walk_start | i_cmd.walk_step;
    assign rd_addr = i_cmd.walk_start ? '0 : eff_next;

    always_comb begin
        wr_en   = i_cmd.wr_alloc | i_cmd.wr_split | i_cmd.wr_free;
        wr_addr = r_cur;
        wr_word = {eff_size, 1'b0, eff_next};
        if (i_cmd.wr_alloc) begin
            wr_addr = r_cur;
            if (can_split) begin
                wr_word = {SW'(r_need), 1'b0, r_count[IW-1:0]};
            end else begin
                wr_word = {eff_size, 1'b0, eff_next};
            end
        end else if (i_cmd.wr_split) begin
            // remainder goes to a fresh slot linked in after the chosen block
            wr_addr = r_count[IW-1:0];
            wr_word = {rest_size, 1'b1, eff_next};
        end else if (i_cmd.wr_free) begin
            wr_addr = r_loc_slot;
            wr_word = {r_loc_size, 1'b1, r_loc_next};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_word;
        end
        if (rd_en) begin
            r_rd_word  <= mem[rd_addr];
            r_rd_fresh <= r_head_fresh && (rd_addr == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_fresh <= 1'b1;
            r_count      <= CW'(1);
            r_done       <= 1'b0;
        end else begin
            if (wr_en && (wr_addr == '0)) begin
                r_head_fresh <= 1'b0;
            end
            if (i_cmd.wr_split) begin
                r_count <= r_count + CW'(1);
            end
            r_done <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_req     <= i_request_bytes;
            r_present <= i_pointer_present;
            r_ptr     <= i_pointer_offset;
            r_need    <= need;
        end
        if (i_cmd.walk_start) begin
            r_cur  <= '0;
            r_addr <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.walk_step) begin
            r_cur  <= eff_next;
            r_addr <= SW'(XW'(r_addr) + XW'(HEADER_BYTES) + XW'(eff_size));
            r_cnt  <= r_cnt + CW'(1);
        end
        if (i_cmd.save_loc) begin
            r_loc_slot <= r_cur;
            r_loc_size <= eff_size;
            r_loc_next <= eff_next;
        end
        if (i_cmd.res_we) begin
            case (i_cmd.res_kind)
                RES_OK_ZERO: begin
                    r_status <= ST_OK;
                    r_result <= '0;
                    r_copy   <= '0;
                end
                RES_OK_PTR: begin
                    r_status <= ST_OK;
                    r_result <= r_ptr;
                    r_copy   <= '0;
                end
                RES_OK_ALLOC: begin
                    r_status <= ST_OK;
                    r_result <= pay_off[OFF_W-1:0];
                    r_copy   <= '0;
                end
                RES_OK_MOVE: begin
                    r_status <= ST_OK;
                    r_result <= pay_off[OFF_W-1:0];
                    r_copy   <= OFF_W'(XW'(r_loc_size));
                end
                RES_NULL: begin
                    r_status <= ST_NULL;
                    r_result <= '0;
                    r_copy   <= '0;
                end
                RES_OOM: begin
                    r_status <= ST_OOM;
                    r_result <= '0;
                    r_copy   <= '0;
                end
                default: begin
                    r_status <= ST_OK;
                    r_result <= '0;
                    r_copy   <= '0;
                end
            endcase
        end
    end

    always_comb begin
        o_stat.op            = r_op;
        o_stat.req_zero      = (r_req == '0);
        o_stat.present       = r_present;
        o_stat.walk_end      = (r_cnt == r_count);
        o_stat.loc_hit       = (pay_off == XW'(r_ptr));
        o_stat.fit_hit       = eff_free && (XW'(eff_size) >= XW'(r_need));
        o_stat.fits_in_place = (XW'(eff_size) >= XW'(r_req));
        o_stat.can_split     = can_split;
    end

    assign o_status        = r_status;
    assign o_result_offset = r_result;
    assign o_copy_bytes    = r_copy;
    assign o_done          = r_done;

endmodule

@@ hdl/first_fit_block_allocator.sv @@
// first_fit_block_allocator: allocate, release and resize over a fixed heap
// top level joining the sequencer ffba_ctrl and the datapath ffba_dpath
// depends on ffba_pkg
//
// Usage: drive i_operation, i_request_bytes, i_pointer_present and
// i_pointer_offset with start high; the item is taken at a clock edge where
// busy is low. busy stays high while the item is worked on. The result
// (o_status, o_result_offset, o_copy_bytes) is shown for exactly one cycle
// with o_done high and must be taken then; the receiver cannot stall it.
// Walks: a request that needs the block chain walks it one block per cycle
// through the table's single read port, then may write the allocated block,
// a split remainder and a freed block to the table; a resize that moves walks
// the chain twice. A new item can be taken in the cycle that o_done is shown.
// Reset leaves one free block spanning the heap and needs no clearing pass;
// the table's other slots are written before they are ever read.
module first_fit_block_allocator #(
    parameter int HEAP_BYTES      = 65536,
    parameter int HEADER_BYTES    = 24,
    parameter int MIN_SPLIT_BYTES = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ffba_pkg::OP_W-1:0]   i_operation,
    input  logic [ffba_pkg::REQ_W-1:0]  i_request_bytes,
    input  logic                        i_pointer_present,
    input  logic [ffba_pkg::OFF_W-1:0]  i_pointer_offset,
    output logic [ffba_pkg::ST_W-1:0]   o_status,
    output logic [ffba_pkg::OFF_W-1:0]  o_result_offset,
    output logic [ffba_pkg::OFF_W-1:0]  o_copy_bytes,
    output logic                        o_done
);
    import ffba_pkg::*;

    t_ffba_cmd  cmd;
    t_ffba_stat stat;

    ffba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    ffba_dpath #(
        .HEAP_BYTES      (HEAP_BYTES),
        .HEADER_BYTES    (HEADER_BYTES),
        .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_operation       (i_operation),
        .i_request_bytes   (i_request_bytes),
        .i_pointer_present (i_pointer_present),
        .i_pointer_offset  (i_pointer_offset),
        .o_stat            (stat),
        .o_status          (o_status),
        .o_result_offset   (o_result_offset),
        .o_copy_bytes      (o_copy_bytes),
        .o_done            (o_done)
    );

endmodule
